>>> design/cbm_pkg.sv
package cbm_pkg;

   // Input operation codes
   typedef enum logic [2:0] {
      OP_REG_WRITE  = 3'd0,
      OP_CPU_MAP    = 3'd1,
      OP_PPU_MAP    = 3'd2,
      OP_TICK       = 3'd3,
      OP_CART_RESET = 3'd4
   } op_type;

   // Result target codes
   typedef enum logic [2:0] {
      TGT_NONE    = 3'd0,
      TGT_PRG_ROM = 3'd1,
      TGT_WORK_RAM = 3'd2,
      TGT_CHR_ROM = 3'd3,
      TGT_CHR_RAM = 3'd4,
      TGT_NAMETABLE = 3'd5
   } target_type;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_PRG_BANK_COUNT = 1'b0,
      CSR_CHR_BANK_COUNT = 1'b1
   } csr_index_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_OUT
   } state_type;

   localparam int PRG_SLOTS  = 4;
   localparam int CHR_SLOTS  = 8;
   localparam int BANK_W     = 16;
   localparam int COUNT_W    = 17;
   localparam int ADDR_W     = 29;
   localparam int PRG_OFF_W  = 13;
   localparam int CHR_OFF_W  = 10;
   localparam int DIV_STEPS  = BANK_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Mapper register window and offsets within it
   localparam logic [15:0] REG_BASE     = 16'h4020;
   localparam logic [15:0] REG_LAST     = 16'h403F;
   localparam logic [4:0]  OFF_PRG_LAST = 5'h07;
   localparam logic [4:0]  OFF_CHR_BASE = 5'h10;
   localparam logic [4:0]  OFF_MIRROR   = 5'h08;
   localparam logic [4:0]  OFF_RAM_PAGE = 5'h09;
   localparam logic [4:0]  OFF_RAM_MODE = 5'h0A;
   localparam logic [4:0]  OFF_IRQ_RELOAD = 5'h0C;
   localparam logic [4:0]  OFF_IRQ_OFF  = 5'h0E;
   localparam logic [4:0]  OFF_IRQ_ON   = 5'h0F;

   // CPU and PPU address windows
   localparam logic [15:0] CPU_PRG_BASE = 16'h8000;
   localparam logic [15:0] CPU_RAM_BASE = 16'h6000;
   localparam logic [13:0] PPU_NT_BASE  = 14'h2000;
   localparam logic [13:0] PPU_PAL_BASE = 14'h3F00;

   // Nametable mirroring modes
   localparam logic [1:0] MIR_VERTICAL   = 2'd0;
   localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
   localparam logic [1:0] MIR_SINGLE_A   = 2'd2;
   localparam logic [1:0] MIR_SINGLE_B   = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

endpackage

>>> design/cbm_controller.sv
module cbm_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  cbm_pkg::status_type  status,
   output cbm_pkg::cmd_type     cmd
);

   cbm_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         cbm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = cbm_pkg::ST_EXEC;
            end
         end
         cbm_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.need_div ? cbm_pkg::ST_DIV : cbm_pkg::ST_OUT;
         end
         cbm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = cbm_pkg::ST_OUT;
            end
         end
         cbm_pkg::ST_OUT: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cbm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/cbm_datapath.sv
module cbm_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [2:0]                 req_operation,
   input  logic [15:0]                req_bus_address,
   input  logic [7:0]                 req_write_data,
   input  logic                       csr_write_enable,
   input  logic [0:0]                 csr_index,
   input  logic [cbm_pkg::COUNT_W-1:0] csr_write_data,
   input  cbm_pkg::cmd_type           cmd,
   output cbm_pkg::status_type        status,
   output logic [2:0]                 rsp_target,
   output logic [cbm_pkg::ADDR_W-1:0] rsp_mem_address,
   output logic                       rsp_irq_line
);

   localparam int BW = cbm_pkg::BANK_W;
   localparam int CW = cbm_pkg::COUNT_W;
   localparam int AW = cbm_pkg::ADDR_W;
   localparam int PW = cbm_pkg::PRG_OFF_W;
   localparam int HW = cbm_pkg::CHR_OFF_W;

   // Configuration and mapper state
   logic [CW-1:0] prg_count_ff, chr_count_ff;
   logic [BW-1:0] prg_bank_ff [cbm_pkg::PRG_SLOTS];
   logic [BW-1:0] prg_bank_in [cbm_pkg::PRG_SLOTS];
   logic [BW-1:0] chr_bank_ff [cbm_pkg::CHR_SLOTS];
   logic [BW-1:0] chr_bank_in [cbm_pkg::CHR_SLOTS];
   logic [1:0]    mirror_ff, mirror_in;
   logic [7:0]    ram_page_ff, ram_page_in;
   logic          ram_mode_ff, ram_mode_in;
   logic          irq_en_ff, irq_en_in;
   logic          irq_flag_ff, irq_flag_in;
   logic [7:0]    irq_cnt_ff, irq_cnt_in;
   logic [7:0]    irq_reload_ff, irq_reload_in;

   // Captured input word
   logic [2:0]    op_ff;
   logic [15:0]   addr_ff;
   logic [7:0]    data_ff;

   // Translation result held across the remainder loop
   logic [2:0]    tgt_ff;
   logic [AW-1:0] direct_ff;
   logic [PW-1:0] off_ff;
   logic          is_prg_ff;
   logic          use_rem_ff;

   // Remainder unit
   logic [BW-1:0] num_ff, rem_ff;
   logic [CW-1:0] den_ff;
   logic [cbm_pkg::DIV_CNT_W-1:0] step_ff;
   logic [CW-1:0] trial;
   logic [BW-1:0] rem_next;

   // Output register
   logic [2:0]    out_tgt_ff;
   logic [AW-1:0] out_addr_ff;
   logic          out_irq_ff;

   // Translation decode
   logic [2:0]    map_tgt;
   logic [AW-1:0] map_direct;
   logic [BW-1:0] map_bank;
   logic [CW-1:0] map_count;
   logic          map_use_rem;
   logic          map_is_prg;
   logic [13:0]   ppu_addr;
   logic          nt_page;

   // Register-write decode and cartridge reset banks
   logic          reg_hit;
   logic [4:0]    reg_off;
   logic [CW-1:0] last_bank, second_bank;

   // Configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= '0;
         chr_count_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            cbm_pkg::CSR_PRG_BANK_COUNT: prg_count_ff <= csr_write_data;
            cbm_pkg::CSR_CHR_BANK_COUNT: chr_count_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Address translation from the captured word
   assign ppu_addr = addr_ff[13:0];

   always_comb begin
      map_tgt     = cbm_pkg::TGT_NONE;
      map_direct  = '0;
      map_bank    = '0;
      map_count   = '0;
      map_use_rem = 1'b0;
      map_is_prg  = 1'b0;
      nt_page     = 1'b0;
      case (mirror_ff)
         cbm_pkg::MIR_VERTICAL:   nt_page = ppu_addr[10];
         cbm_pkg::MIR_HORIZONTAL: nt_page = ppu_addr[11];
         cbm_pkg::MIR_SINGLE_A:   nt_page = 1'b0;
         cbm_pkg::MIR_SINGLE_B:   nt_page = 1'b1;
         default:                 nt_page = 1'b0;
      endcase
      case (op_ff)
         cbm_pkg::OP_CPU_MAP: begin
            if (addr_ff >= cbm_pkg::CPU_PRG_BASE) begin
               map_tgt     = cbm_pkg::TGT_PRG_ROM;
               map_bank    = prg_bank_ff[addr_ff[14:13]];
               map_count   = prg_count_ff;
               map_use_rem = 1'b1;
               map_is_prg  = 1'b1;
            end else if (addr_ff >= cbm_pkg::CPU_RAM_BASE) begin
               if (ram_mode_ff) begin
                  map_tgt     = cbm_pkg::TGT_PRG_ROM;
                  map_bank    = {{(BW-8){1'b0}}, ram_page_ff};
                  map_count   = prg_count_ff;
                  map_use_rem = 1'b1;
                  map_is_prg  = 1'b1;
               end else begin
                  // 256 pages: the page number needs no wrap
                  map_tgt    = cbm_pkg::TGT_WORK_RAM;
                  map_direct = {{(AW-8-PW){1'b0}}, ram_page_ff, addr_ff[PW-1:0]};
               end
            end
         end
         cbm_pkg::OP_PPU_MAP: begin
            if (ppu_addr < cbm_pkg::PPU_NT_BASE) begin
               if (chr_count_ff != '0) begin
                  map_tgt     = cbm_pkg::TGT_CHR_ROM;
                  map_bank    = chr_bank_ff[ppu_addr[12:10]];
                  map_count   = chr_count_ff;
                  map_use_rem = 1'b1;
               end else begin
                  map_tgt    = cbm_pkg::TGT_CHR_RAM;
                  map_direct = {{(AW-PW){1'b0}}, ppu_addr[PW-1:0]};
               end
            end else if (ppu_addr < cbm_pkg::PPU_PAL_BASE) begin
               map_tgt    = cbm_pkg::TGT_NAMETABLE;
               map_direct = {{(AW-HW-1){1'b0}}, nt_page, ppu_addr[HW-1:0]};
            end
         end
         default: ;
      endcase
   end

   // A zero count skips the loop; the cleared remainder gives bank 0
   assign status.need_div = map_use_rem && (map_count != '0);
   assign status.div_last = (step_ff == cbm_pkg::DIV_CNT_W'(cbm_pkg::DIV_STEPS - 1));

   // Mapper state updates
   assign reg_hit   = (addr_ff >= cbm_pkg::REG_BASE) && (addr_ff <= cbm_pkg::REG_LAST);
   assign reg_off   = addr_ff[4:0];
   assign last_bank = (prg_count_ff != '0) ? prg_count_ff - CW'(1) : '0;
   assign second_bank = (prg_count_ff >= CW'(2)) ? prg_count_ff - CW'(2) : last_bank;

   always_comb begin
      prg_bank_in   = prg_bank_ff;
      chr_bank_in   = chr_bank_ff;
      mirror_in     = mirror_ff;
      ram_page_in   = ram_page_ff;
      ram_mode_in   = ram_mode_ff;
      irq_en_in     = irq_en_ff;
      irq_flag_in   = irq_flag_ff;
      irq_cnt_in    = irq_cnt_ff;
      irq_reload_in = irq_reload_ff;
      if (cmd.exec) begin
         case (op_ff)
            cbm_pkg::OP_REG_WRITE: begin
               if (reg_hit) begin
                  if (reg_off >= cbm_pkg::OFF_CHR_BASE) begin
                     if (reg_off[0]) begin
                        chr_bank_in[reg_off[3:1]][15:8] = data_ff;
                     end else begin
                        chr_bank_in[reg_off[3:1]][7:0] = data_ff;
                     end
                  end else if (reg_off <= cbm_pkg::OFF_PRG_LAST) begin
                     if (reg_off[0]) begin
                        prg_bank_in[reg_off[2:1]][15:8] = data_ff;
                     end else begin
                        prg_bank_in[reg_off[2:1]][7:0] = data_ff;
                     end
                  end else begin
                     case (reg_off)
                        cbm_pkg::OFF_MIRROR:     mirror_in     = data_ff[1:0];
                        cbm_pkg::OFF_RAM_PAGE:   ram_page_in   = data_ff;
                        cbm_pkg::OFF_RAM_MODE:   ram_mode_in   = data_ff[0];
                        cbm_pkg::OFF_IRQ_RELOAD: irq_reload_in = data_ff;
                        cbm_pkg::OFF_IRQ_OFF: begin
                           irq_en_in   = 1'b0;
                           irq_flag_in = 1'b0;
                           irq_cnt_in  = irq_reload_ff;
                        end
                        cbm_pkg::OFF_IRQ_ON: begin
                           irq_en_in   = 1'b1;
                           irq_flag_in = 1'b0;
                           irq_cnt_in  = irq_reload_ff;
                        end
                        default: ;
                     endcase
                  end
               end
            end
            cbm_pkg::OP_TICK: begin
               if (irq_en_ff && !irq_flag_ff) begin
                  if (irq_cnt_ff == 8'd0) begin
                     irq_flag_in = 1'b1;
                  end else begin
                     irq_cnt_in = irq_cnt_ff - 8'd1;
                  end
               end
            end
            cbm_pkg::OP_CART_RESET: begin
               prg_bank_in[0] = BW'(0);
               prg_bank_in[1] = BW'(1);
               prg_bank_in[2] = second_bank[BW-1:0];
               prg_bank_in[3] = last_bank[BW-1:0];
               for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++) begin
                  chr_bank_in[i] = BW'(i);
               end
               mirror_in     = cbm_pkg::MIR_VERTICAL;
               irq_en_in     = 1'b0;
               irq_flag_in   = 1'b0;
               irq_cnt_in    = 8'd0;
               irq_reload_in = 8'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_bank_ff[0] <= BW'(0);
         prg_bank_ff[1] <= BW'(1);
         prg_bank_ff[2] <= BW'(0);
         prg_bank_ff[3] <= BW'(0);
         for (int i = 0; i < cbm_pkg::CHR_SLOTS; i++) begin
            chr_bank_ff[i] <= BW'(i);
         end
         mirror_ff     <= cbm_pkg::MIR_VERTICAL;
         ram_page_ff   <= 8'd0;
         ram_mode_ff   <= 1'b0;
         irq_en_ff     <= 1'b0;
         irq_flag_ff   <= 1'b0;
         irq_cnt_ff    <= 8'd0;
         irq_reload_ff <= 8'd0;
      end else begin
         prg_bank_ff   <= prg_bank_in;
         chr_bank_ff   <= chr_bank_in;
         mirror_ff     <= mirror_in;
         ram_page_ff   <= ram_page_in;
         ram_mode_ff   <= ram_mode_in;
         irq_en_ff     <= irq_en_in;
         irq_flag_ff   <= irq_flag_in;
         irq_cnt_ff    <= irq_cnt_in;
         irq_reload_ff <= irq_reload_in;
      end
   end

   // Input capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         addr_ff <= req_bus_address;
         data_ff <= req_write_data;
      end
   end

   // Restoring remainder, one dividend bit per step
   assign trial    = {rem_ff, num_ff[BW-1]};
   assign rem_next = (trial >= den_ff) ? BW'(trial - den_ff) : trial[BW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         tgt_ff     <= map_tgt;
         direct_ff  <= map_direct;
         off_ff     <= addr_ff[PW-1:0];
         is_prg_ff  <= map_is_prg;
         use_rem_ff <= map_use_rem;
         num_ff     <= map_bank;
         rem_ff     <= '0;
         den_ff     <= map_count;
         step_ff    <= '0;
      end else if (cmd.div_step) begin
         num_ff  <= {num_ff[BW-2:0], 1'b0};
         rem_ff  <= rem_next;
         step_ff <= step_ff + cbm_pkg::DIV_CNT_W'(1);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_tgt_ff <= tgt_ff;
         out_irq_ff <= irq_flag_ff;
         if (!use_rem_ff) begin
            out_addr_ff <= direct_ff;
         end else if (is_prg_ff) begin
            out_addr_ff <= {rem_ff, off_ff};
         end else begin
            out_addr_ff <= {{(AW-BW-HW){1'b0}}, rem_ff, off_ff[HW-1:0]};
         end
      end
   end

   assign rsp_target      = out_tgt_ff;
   assign rsp_mem_address = out_addr_ff;
   assign rsp_irq_line    = out_irq_ff;

endmodule

>>> design/cartridge_bank_mapper_scanline_irq_core.sv
// Cartridge bank mapper with a scanline interrupt counter.
// Request channel (req_*): one word per operation: register write, CPU
// address map, PPU address map, scanline tick or cartridge reset.
// Response channel (rsp_*): exactly one word per request, in order: the
// target memory, the byte address in it and the IRQ level after the request.
// Configuration (csr_*): PRG and CHR bank counts; the user must see that
// they are written only while idle, as the block itself does not enforce it.
// A PRG or CHR ROM lookup with a nonzero bank count passes through a
// 16-step restoring remainder unit that wraps the bank number by the count.
// One request is processed at a time: a new word is accepted in the cycle
// after the previous response is loaded.
// The response sits in an output register; if the receiver stalls, the
// block finishes the next word and then holds it until that register frees.
// Synchronous reset returns all bank, mirroring, RAM and IRQ state and both
// bank counts to their power-up values and empties the response register.
module cartridge_bank_mapper_scanline_irq_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_operation,
   input  logic [15:0]                req_bus_address,
   input  logic [7:0]                 req_write_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [2:0]                 rsp_target,
   output logic [cbm_pkg::ADDR_W-1:0] rsp_mem_address,
   output logic                       rsp_irq_line,
   input  logic                       csr_write_enable,
   input  logic [0:0]                 csr_index,
   input  logic [cbm_pkg::COUNT_W-1:0] csr_write_data
);

   cbm_pkg::cmd_type    cmd;
   cbm_pkg::status_type status;

   // Sequencer
   cbm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Mapper state, translation and remainder unit
   cbm_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_bus_address  (req_bus_address),
      .req_write_data   (req_write_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_target       (rsp_target),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_irq_line     (rsp_irq_line)
   );

endmodule

>>> design/cbm_checker.sv
module cbm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [2:0]                 rsp_target,
   input logic [cbm_pkg::ADDR_W-1:0] rsp_mem_address,
   input logic                       rsp_irq_line
);

   // A stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target)
         && $stable(rsp_mem_address) && $stable(rsp_irq_line))
      else $error("stalled response word changed");

   // No target means a zero address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_target == cbm_pkg::TGT_NONE) |-> (rsp_mem_address == '0))
      else $error("nonzero address with no target");

   // CHR RAM stays inside 8KB, nametable RAM inside 2KB
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_target == cbm_pkg::TGT_CHR_RAM)
         |-> (rsp_mem_address[cbm_pkg::ADDR_W-1:13] == '0))
      else $error("CHR RAM address out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_target == cbm_pkg::TGT_NAMETABLE)
         |-> (rsp_mem_address[cbm_pkg::ADDR_W-1:11] == '0))
      else $error("nametable address out of range");

   // Reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind cartridge_bank_mapper_scanline_irq_core cbm_checker u_chk (.*);
